// ===== hdl/servo_drive_state_control_autoreset_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the servo drive state control block
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_DRIVE_STATE_CONTROL_AUTORESET_ASSERT_SVH
`define SERVO_DRIVE_STATE_CONTROL_AUTORESET_ASSERT_SVH

// ante implies cons in the same cycle
`define SDSC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdsc same-cycle check failed");

// ante implies cons in the next cycle
`define SDSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdsc next-cycle check failed");

`endif

// ===== hdl/sdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdsc_pkg
// Shared widths, bit positions, register indexes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsc_pkg;

    localparam int STATUS_W = 16;
    localparam int CW_W     = 16;
    localparam int HOLD_W   = 16;
    localparam int RETRY_W  = 8;
    localparam int MOTION_W = 3;
    localparam int CFG_W    = 16;

    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd100;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd3;

    // status word bit positions
    localparam int SW_READY      = 0;
    localparam int SW_SWITCHED   = 1;
    localparam int SW_OP_ENABLED = 2;
    localparam int SW_FAULT      = 3;
    localparam int SW_VOLTAGE    = 4;
    localparam int SW_QUICK_STOP = 5;
    localparam int SW_ON_DISABLE = 6;
    localparam int SW_WARNING    = 7;
    localparam int SW_REMOTE     = 9;
    localparam int SW_MOTION_LSB = 10;

    // control word bit positions
    localparam int CW_SWITCH_ON   = 0;
    localparam int CW_EN_VOLTAGE  = 1;
    localparam int CW_QUICK_STOP  = 2;
    localparam int CW_EN_OP       = 3;
    localparam int CW_FAULT_RESET = 7;
    localparam int CW_HALT        = 8;

    typedef enum logic [0:0] {
        CFG_HOLD_PERIODS = 1'b0,
        CFG_RETRY_LIMIT  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                ready;
        logic                powered;
        logic                op_enabled;
        logic                voltage_on;
        logic                quick_stopped;
        logic                inhibited;
        logic                warning;
        logic                remote;
        logic [MOTION_W-1:0] motion;
    } t_status;

    typedef struct packed {
        logic run_req;
        logic enable_voltage;
        logic quick_stop_n;
        logic enable_operation;
        logic clear_fault;
        logic halt;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/sdsc_decode.sv =====
// ----------------------------------------------------------------------------
// sdsc_decode
// Status word decode; all status flags forced low while the link is down (raw fault bit is not).
// ----------------------------------------------------------------------------
`default_nettype none

module sdsc_decode (
    input  wire logic                         i_link_up,
    input  wire logic [sdsc_pkg::STATUS_W-1:0] i_status_word,
    output sdsc_pkg::t_status                 o_status,
    output logic                              o_fault_raw
);
    import sdsc_pkg::*;

    always_comb begin
        o_status = '0;
        if (i_link_up) begin
            o_status.ready         = i_status_word[SW_READY];
            o_status.powered       = i_status_word[SW_SWITCHED];
            o_status.op_enabled    = i_status_word[SW_OP_ENABLED];
            o_status.voltage_on    = i_status_word[SW_VOLTAGE];
            o_status.quick_stopped = ~i_status_word[SW_QUICK_STOP];
            o_status.inhibited     = i_status_word[SW_ON_DISABLE];
            o_status.warning       = i_status_word[SW_WARNING];
            o_status.remote        = i_status_word[SW_REMOTE];
            o_status.motion        = i_status_word[SW_MOTION_LSB +: MOTION_W];
        end
    end

    assign o_fault_raw = i_status_word[SW_FAULT];

endmodule

`default_nettype wire

// ===== hdl/sdsc_autoreset.sv =====
// ----------------------------------------------------------------------------
// sdsc_autoreset
// Fault auto-reset sequencer, config registers and control word build.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_drive_state_control_autoreset_assert.svh"

module sdsc_autoreset (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [sdsc_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                       i_step,
    input  wire logic                       i_link_up,
    input  wire logic                       i_fault_raw,
    input  wire logic                       i_switched_on,
    input  wire sdsc_pkg::t_cmd             i_cmd,
    output logic [sdsc_pkg::CW_W-1:0]       o_control_word,
    output logic                            o_fault,
    output logic                            o_busy
);
    import sdsc_pkg::*;

    logic [HOLD_W-1:0]  r_hold;
    logic [RETRY_W-1:0] r_limit;
    logic               r_prev_on;
    logic               r_fault_seen;
    logic [RETRY_W-1:0] r_retries;
    logic               r_phase;
    logic [HOLD_W-1:0]  r_count;

    logic               n_fault_seen;
    logic [RETRY_W-1:0] n_retries;
    logic               n_phase;
    logic [HOLD_W-1:0]  n_count;
    logic [RETRY_W-1:0] seq_retries;
    logic               seq_phase;
    logic [HOLD_W-1:0]  seq_count;
    logic               rise_on;
    logic               arm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= HOLD_RESET;
            r_limit <= RETRY_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HOLD_PERIODS: r_hold  <= i_cfg_data[HOLD_W-1:0];
                CFG_RETRY_LIMIT:  r_limit <= i_cfg_data[RETRY_W-1:0];
                default:          r_hold  <= r_hold;
            endcase
        end
    end

    always_comb begin
        n_fault_seen = i_link_up ? i_fault_raw : r_fault_seen;
        // a clear fault bit cancels the sequence
        seq_retries  = (i_link_up && !i_fault_raw) ? '0 : r_retries;
        seq_phase    = r_phase;
        seq_count    = r_count;
        o_fault      = 1'b1;
        if (i_link_up) begin
            if (seq_retries != '0) begin
                o_fault = 1'b0;
                if (r_count < r_hold) begin
                    seq_count = r_count + 16'd1;
                end else begin
                    seq_count = '0;
                    seq_phase = ~r_phase;
                    if (!r_phase) begin
                        seq_retries = seq_retries - 8'd1;
                    end
                end
            end else begin
                o_fault = i_fault_raw;
            end
        end

        rise_on = i_cmd.run_req & ~r_prev_on;
        arm     = (r_limit != '0) && (r_hold != '0) && rise_on && n_fault_seen;

        n_retries = arm ? r_limit : seq_retries;
        n_phase   = arm ? 1'b1    : seq_phase;
        n_count   = arm ? '0      : seq_count;
        o_busy    = (n_retries != '0);

        o_control_word                 = '0;
        o_control_word[CW_EN_VOLTAGE]  = i_cmd.enable_voltage;
        o_control_word[CW_QUICK_STOP]  = ~i_cmd.quick_stop_n;
        o_control_word[CW_FAULT_RESET] = i_cmd.clear_fault | (o_busy & n_phase);
        o_control_word[CW_HALT]        = i_cmd.halt;
        if (!o_busy) begin
            o_control_word[CW_SWITCH_ON] = i_cmd.run_req;
            o_control_word[CW_EN_OP]     = i_cmd.enable_operation & i_switched_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_on    <= 1'b0;
            r_fault_seen <= 1'b0;
            r_retries    <= '0;
            r_phase      <= 1'b0;
            r_count      <= '0;
        end else if (i_step) begin
            r_prev_on    <= i_cmd.run_req;
            r_fault_seen <= n_fault_seen;
            r_retries    <= n_retries;
            r_phase      <= n_phase;
            r_count      <= n_count;
        end
    end

    // a live sequence always has a recorded fault behind it
    `SDSC_ASSERT_NOW(a_busy_needs_fault, i_clk, i_rst_n, r_retries != '0, r_fault_seen)
    // sequencer state moves only when an item is processed
    `SDSC_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_step,
        $stable(r_retries) && $stable(r_phase) && $stable(r_count))
    // link down keeps the recorded fault bit
    `SDSC_ASSERT_NEXT(a_link_down_keeps_fault, i_clk, i_rst_n, i_step && !i_link_up,
        $stable(r_fault_seen))

endmodule

`default_nettype wire

// ===== hdl/servo_drive_state_control_autoreset.sv =====
// ----------------------------------------------------------------------------
// servo_drive_state_control_autoreset
// Drive status decode, control word build and fault auto-reset, one item per
// servo period.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | i_in_valid / o_in_ready    | link, status word, six command bits
//  out     | o_out_valid / i_out_ready  | control word, fault, status flags
//  cfg     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
//  Two register stages: an input register and a result register, with the
//  decode, sequencer step and control word logic between them.
//  An accepted item is registered in the input register, then in the result
//  register, where its result is valid; one item per cycle sustained while
//  the output does not stall, since the sequencer state updates on each step.
//  The input register keeps accepting while a result waits, until both
//  stages are full; a stall on the output then backs up into o_in_ready.
//  Synchronous active-low reset clears valids, sequencer state and config
//  registers (hold 100 periods, 3 retries).
// ----------------------------------------------------------------------------
`default_nettype none

module servo_drive_state_control_autoreset (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [sdsc_pkg::CFG_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_link_up,
    input  wire logic [sdsc_pkg::STATUS_W-1:0] i_status_word,
    input  wire logic                          i_cmd_switch_on,
    input  wire logic                          i_cmd_enable_voltage,
    input  wire logic                          i_cmd_quick_stop_n,
    input  wire logic                          i_cmd_enable_operation,
    input  wire logic                          i_cmd_fault_reset,
    input  wire logic                          i_cmd_halt,
    // result items
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [sdsc_pkg::CW_W-1:0]          o_control_word,
    output logic                               o_fault_out,
    output logic                               o_ready_out,
    output logic                               o_switched_on_out,
    output logic                               o_op_enabled_out,
    output logic                               o_voltage_on_out,
    output logic                               o_quick_stopped_out,
    output logic                               o_on_disabled_out,
    output logic                               o_warning_out,
    output logic                               o_remote_out,
    output logic [sdsc_pkg::MOTION_W-1:0]      o_motion_flags,
    output logic                               o_autoreset_busy
);
    import sdsc_pkg::*;

    // input stage
    logic                r_in_valid;
    logic                r_in_link;
    logic [STATUS_W-1:0] r_in_status;
    t_cmd                r_in_cmd;

    // result stage
    logic                r_out_valid;
    logic [CW_W-1:0]     r_out_cw;
    logic                r_out_fault;
    t_status             r_out_status;
    logic                r_out_busy;

    logic                in_take;
    logic                step;
    t_status             dec_status;
    logic                dec_fault_raw;
    logic [CW_W-1:0]     seq_cw;
    logic                seq_fault;
    logic                seq_busy;

    // an item moves to the result stage when that stage is empty or draining
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_link                 <= i_link_up;
            r_in_status               <= i_status_word;
            r_in_cmd.run_req          <= i_cmd_switch_on;
            r_in_cmd.enable_voltage   <= i_cmd_enable_voltage;
            r_in_cmd.quick_stop_n     <= i_cmd_quick_stop_n;
            r_in_cmd.enable_operation <= i_cmd_enable_operation;
            r_in_cmd.clear_fault      <= i_cmd_fault_reset;
            r_in_cmd.halt             <= i_cmd_halt;
        end
    end

    sdsc_decode u_decode (
        .i_link_up     (r_in_link),
        .i_status_word (r_in_status),
        .o_status      (dec_status),
        .o_fault_raw   (dec_fault_raw)
    );

    sdsc_autoreset u_autoreset (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_step         (step),
        .i_link_up      (r_in_link),
        .i_fault_raw    (dec_fault_raw),
        .i_switched_on  (dec_status.powered),
        .i_cmd          (r_in_cmd),
        .o_control_word (seq_cw),
        .o_fault        (seq_fault),
        .o_busy         (seq_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= step || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_cw     <= seq_cw;
            r_out_fault  <= seq_fault;
            r_out_status <= dec_status;
            r_out_busy   <= seq_busy;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_control_word      = r_out_cw;
    assign o_fault_out         = r_out_fault;
    assign o_ready_out         = r_out_status.ready;
    assign o_switched_on_out   = r_out_status.powered;
    assign o_op_enabled_out    = r_out_status.op_enabled;
    assign o_voltage_on_out    = r_out_status.voltage_on;
    assign o_quick_stopped_out = r_out_status.quick_stopped;
    assign o_on_disabled_out   = r_out_status.inhibited;
    assign o_warning_out       = r_out_status.warning;
    assign o_remote_out        = r_out_status.remote;
    assign o_motion_flags      = r_out_status.motion;
    assign o_autoreset_busy    = r_out_busy;

endmodule

`default_nettype wire

// ===== tb/tb_servo_drive_state_control_autoreset.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_drive_state_control_autoreset
// Self-checking bench for the servo drive state control block. A queue of
// servo periods feeds a valid/ready driver. A monitor predicts each accepted
// period and compares every field of every returned result. Register
// settings change between idle phases, and so do the idling patterns.
// ----------------------------------------------------------------------------

module tb_servo_drive_state_control_autoreset;
    import sdsc_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off that fills the pipe
    // The slowest correct run goes quiet for the hold-off plus a few random
    // stall runs. This limit is many times that.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;     // settle time after the last result
    localparam int PHASE_ITEMS    = 185;

    // one servo period as offered to the block
    typedef struct packed {
        logic                link_up;
        logic [STATUS_W-1:0] status_word;
        t_cmd                cmd;
    } t_period_in;

    // what the block should return for that period
    typedef struct packed {
        logic [CW_W-1:0] control_word;
        logic            fault;
        t_status         status;
        logic            busy;
    } t_period_out;

    // ------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                i_clk                  = 1'b0;
    logic                i_rst_n                = 1'b0;
    logic                i_cfg_we               = 1'b0;
    logic [0:0]          i_cfg_index            = CFG_HOLD_PERIODS;
    logic [CFG_W-1:0]    i_cfg_data             = '0;
    logic                i_in_valid             = 1'b0;
    logic                o_in_ready;
    logic                i_link_up              = 1'b0;
    logic [STATUS_W-1:0] i_status_word          = '0;
    logic                i_cmd_switch_on        = 1'b0;
    logic                i_cmd_enable_voltage   = 1'b0;
    logic                i_cmd_quick_stop_n     = 1'b0;
    logic                i_cmd_enable_operation = 1'b0;
    logic                i_cmd_fault_reset      = 1'b0;
    logic                i_cmd_halt             = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready            = 1'b0;
    logic [CW_W-1:0]     o_control_word;
    logic                o_fault_out;
    logic                o_ready_out;
    logic                o_switched_on_out;
    logic                o_op_enabled_out;
    logic                o_voltage_on_out;
    logic                o_quick_stopped_out;
    logic                o_on_disabled_out;
    logic                o_warning_out;
    logic                o_remote_out;
    logic [MOTION_W-1:0] o_motion_flags;
    logic                o_autoreset_busy;

    servo_drive_state_control_autoreset DUT (.*);

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------
    t_period_in  pending_periods[$];   // not yet offered
    t_period_out expected_outputs[$];  // accepted, result not yet seen
    int          queued_count    = 0;  // periods handed to the driver
    int          accepted_count  = 0;  // periods taken by the block
    int          fail_count      = 0;
    logic        in_taken        = 1'b0;
    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    int          hold_requested  = 0;
    int          quiet_cycles    = 0;

    // ------------------------------------------------------------------
    // Predictor state: register copies and sequencer
    // ------------------------------------------------------------------
    logic [HOLD_W-1:0]  hold_periods     = HOLD_RESET;
    logic [RETRY_W-1:0] retry_limit      = RETRY_RESET;
    logic               prev_switch_on   = 1'b0;
    logic               fault_latched    = 1'b0;
    logic [RETRY_W-1:0] seq_retries_left = '0;
    logic               seq_reset_phase  = 1'b0;
    logic [HOLD_W-1:0]  seq_phase_count  = '0;

    // Status half first (decode, latch fault, step sequencer), then command
    // half (switch-on edge, arming, control word).
    function automatic t_period_out drive_period_outputs(input t_period_in p);
        t_period_out res;
        logic        rise_on;
        res = '0;
        if (!p.link_up) begin
            // link down: flags stay zero, sequencer frozen, fault forced
            res.fault = 1'b1;
        end else begin
            res.status.ready         = p.status_word[SW_READY];
            res.status.powered       = p.status_word[SW_SWITCHED];
            res.status.op_enabled    = p.status_word[SW_OP_ENABLED];
            res.status.voltage_on    = p.status_word[SW_VOLTAGE];
            res.status.quick_stopped = ~p.status_word[SW_QUICK_STOP];
            res.status.inhibited     = p.status_word[SW_ON_DISABLE];
            res.status.warning       = p.status_word[SW_WARNING];
            res.status.remote        = p.status_word[SW_REMOTE];
            res.status.motion        = p.status_word[SW_MOTION_LSB +: MOTION_W];
            fault_latched            = p.status_word[SW_FAULT];
            // fault gone: sequencer cancelled before it steps
            if (!fault_latched)
                seq_retries_left = '0;
            if (seq_retries_left != 0) begin
                if (seq_phase_count < hold_periods) begin
                    seq_phase_count = seq_phase_count + 16'd1;
                end else begin
                    seq_phase_count = '0;
                    seq_reset_phase = ~seq_reset_phase;
                    if (seq_reset_phase)
                        seq_retries_left = seq_retries_left - 8'd1;
                end
                res.fault = 1'b0;   // masked while busy
            end else begin
                res.fault = fault_latched;
            end
        end

        rise_on        = p.cmd.run_req & ~prev_switch_on;
        prev_switch_on = p.cmd.run_req;
        // arming reloads even when already busy
        if (retry_limit != 0 && hold_periods != 0 && rise_on && fault_latched) begin
            seq_retries_left = retry_limit;
            seq_reset_phase  = 1'b1;
            seq_phase_count  = '0;
        end

        res.control_word[CW_EN_VOLTAGE]  = p.cmd.enable_voltage;
        res.control_word[CW_QUICK_STOP]  = ~p.cmd.quick_stop_n;
        res.control_word[CW_FAULT_RESET] = p.cmd.clear_fault;
        res.control_word[CW_HALT]        = p.cmd.halt;
        if (seq_retries_left != 0) begin
            if (seq_reset_phase)
                res.control_word[CW_FAULT_RESET] = 1'b1;
        end else begin
            res.control_word[CW_SWITCH_ON] = p.cmd.run_req;
            res.control_word[CW_EN_OP]     = p.cmd.enable_operation
                                             & res.status.powered;
        end
        res.busy = (seq_retries_left != 0);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: new item only when the slot is empty or was just taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : in_driver
        t_period_in p;
        if (!i_in_valid || in_taken) begin
            if (i_rst_n && pending_periods.size() != 0
                    && $urandom_range(99) >= sender_idle_pct) begin
                p = pending_periods.pop_front();
                i_in_valid             <= 1'b1;
                i_link_up              <= p.link_up;
                i_status_word          <= p.status_word;
                i_cmd_switch_on        <= p.cmd.run_req;
                i_cmd_enable_voltage   <= p.cmd.enable_voltage;
                i_cmd_quick_stop_n     <= p.cmd.quick_stop_n;
                i_cmd_enable_operation <= p.cmd.enable_operation;
                i_cmd_fault_reset      <= p.cmd.clear_fault;
                i_cmd_halt             <= p.cmd.halt;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : out_receiver
        int hold_served;
        int hold_left;
        if (hold_served != hold_requested) begin
            hold_served = hold_requested;
            hold_left   = HOLDOFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_period_in  seen;
        t_period_out want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            seen.link_up              = i_link_up;
            seen.status_word          = i_status_word;
            seen.cmd.run_req          = i_cmd_switch_on;
            seen.cmd.enable_voltage   = i_cmd_enable_voltage;
            seen.cmd.quick_stop_n     = i_cmd_quick_stop_n;
            seen.cmd.enable_operation = i_cmd_enable_operation;
            seen.cmd.clear_fault      = i_cmd_fault_reset;
            seen.cmd.halt             = i_cmd_halt;
            expected_outputs.push_back(drive_period_outputs(seen));
            accepted_count <= accepted_count + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outputs.size() == 0) begin
                $error("result item with no expectation pending");
                fail_count++;
            end else begin
                want = expected_outputs.pop_front();
                check_field("control_word", want.control_word, o_control_word);
                check_field("fault_out", 16'(want.fault), 16'(o_fault_out));
                check_field("ready_out", 16'(want.status.ready), 16'(o_ready_out));
                check_field("switched_on_out", 16'(want.status.powered),
                            16'(o_switched_on_out));
                check_field("op_enabled_out", 16'(want.status.op_enabled),
                            16'(o_op_enabled_out));
                check_field("voltage_on_out", 16'(want.status.voltage_on),
                            16'(o_voltage_on_out));
                check_field("quick_stopped_out", 16'(want.status.quick_stopped),
                            16'(o_quick_stopped_out));
                check_field("on_disabled_out", 16'(want.status.inhibited),
                            16'(o_on_disabled_out));
                check_field("warning_out", 16'(want.status.warning), 16'(o_warning_out));
                check_field("remote_out", 16'(want.status.remote), 16'(o_remote_out));
                check_field("motion_flags", 16'(want.status.motion), 16'(o_motion_flags));
                check_field("autoreset_busy", 16'(want.busy), 16'(o_autoreset_busy));
            end
        end
    end

    // watchdog: too long with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("servo_drive_state_control_autoreset verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_period(input logic link, input logic [STATUS_W-1:0] sw,
                              input t_cmd c);
        pending_periods.push_back('{link_up: link, status_word: sw, cmd: c});
        queued_count++;
    endtask

    // Well-formed fault episode: fault bit held, switch-on low then high, so
    // the sequencer arms. Occasional switch-on drops re-arm it, rare link
    // drops freeze it, and the episode may end with the fault cleared.
    task automatic add_fault_episode(input int len);
        t_cmd            c;
        logic [STATUS_W-1:0] sw;
        for (int k = 0; k < len; k++) begin
            c           = t_cmd'($urandom_range(63));
            c.run_req   = (k != 0) && ($urandom_range(15) != 0);
            sw          = 16'($urandom_range(16'hFFFF));
            sw[SW_FAULT] = !(k == len - 1 && $urandom_range(1) == 1);
            add_period($urandom_range(19) != 0, sw, c);
        end
    endtask

    task automatic add_random_periods(input int n);
        int added;
        int len;
        added = 0;
        while (added < n) begin
            if ($urandom_range(9) < 7) begin
                len = $urandom_range(4, 40);
                if (len > n - added)
                    len = n - added;
                add_fault_episode(len);
                added += len;
            end else begin
                // noise: anything the fields allow
                add_period($urandom_range(3) != 0, 16'($urandom_range(16'hFFFF)),
                           t_cmd'($urandom_range(63)));
                added++;
            end
        end
    endtask

    // returns at a falling edge once every queued item has come back
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (accepted_count != queued_count || expected_outputs.size() != 0);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        if (idx == CFG_HOLD_PERIODS)
            hold_periods = data;
        else
            retry_limit = data[RETRY_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_phase(input logic [HOLD_W-1:0] hold, input logic [RETRY_W-1:0] retries,
                             input int idle_pct, input int stall, input bit holdoff);
        wait_drained();
        write_cfg(CFG_HOLD_PERIODS, hold);
        // upper data bits are don't-care for the retry register
        write_cfg(CFG_RETRY_LIMIT, {8'($urandom_range(255)), retries});
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        if (holdoff)
            hold_requested++;
        add_random_periods(PHASE_ITEMS);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed periods under reset registers (hold 100, 3 retries).
        // Command literal order: on, volt, qs_n, en_op, fault_rst, halt.
        add_period(1'b1, 16'h0000, 6'b000000);  // all low, quick stop active
        add_period(1'b1, 16'hFFFF, 6'b011111);  // every status bit, fault, no edge
        add_period(1'b1, 16'h0008, 6'b110100);  // switch-on edge with fault: arm
        add_period(1'b0, 16'hFFFF, 6'b111111);  // link down while busy
        repeat (3)
            add_period(1'b1, 16'h000A, 6'b110100);  // busy, counting
        add_period(1'b1, 16'h000A, 6'b010100);  // switch-on drops
        add_period(1'b1, 16'h000A, 6'b110100);  // re-arm while busy
        add_period(1'b1, 16'h0002, 6'b111100);  // fault clears: cancel
        add_period(1'b1, 16'hFC00, 6'b000001);  // motion bits and above, halt
        add_period(1'b1, 16'h03FF, 6'b001110);
        add_period(1'b1, 16'h0008, 6'b000000);  // fault latched, switch-on low
        add_period(1'b0, 16'h0000, 6'b100000);  // edge with link down arms on latch
        add_period(1'b1, 16'h0008, 6'b100010);  // busy plus manual fault reset
        add_period(1'b0, 16'h0000, 6'b000000);
        add_period(1'b1, 16'h0020, 6'b001000);  // quick stop bit set, no fault
        add_period(1'b1, 16'h1C00, 6'b000101);
        add_period(1'b1, 16'hFFF7, 6'b111111);  // everything but the fault

        // Random phases: register extremes and every idling pattern
        run_phase(16'd2,     8'd2,   0,  0,  1'b0);
        run_phase(16'd0,     8'd3,   59, 0,  1'b0);  // arming disabled by hold
        run_phase(16'd1,     8'd0,   0,  59, 1'b0);  // arming disabled by retries
        run_phase(16'hFFFF,  8'hFF,  30, 30, 1'b0);
        run_phase(16'd1,     8'hFF,  0,  0,  1'b1);  // long hold-off, pipe fills
        run_phase(16'd3,     8'd1,   59, 0,  1'b0);
        run_phase(16'($urandom_range(1, 8)), 8'($urandom_range(1, 6)), 0, 59, 1'b0);
        run_phase(16'($urandom_range(1, 8)), 8'($urandom_range(1, 6)), 30, 30, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);   // catch any stray result
        if (fail_count == 0)
            $display("servo_drive_state_control_autoreset verification clean");
        else
            $display("servo_drive_state_control_autoreset verification failed");
        $finish;
    end

endmodule
